// ----- rtl/core/pbm_pkg.sv -----
package pbm_pkg;

	// blend mode codes
	localparam logic [1:0] MODE_COPY  = 2'd0;
	localparam logic [1:0] MODE_OVER  = 2'd1;
	localparam logic [1:0] MODE_ADD   = 2'd2;
	localparam logic [1:0] MODE_SUB   = 2'd3;

	localparam logic [1:0] MODE_RESET = MODE_OVER;

	localparam int NUM_CHAN = 4;

	typedef logic [1:0]  mode_t;
	typedef logic [15:0] src_chan_t;
	typedef logic [7:0]  pix_chan_t;

	// channel order: red, green, blue, alpha
	typedef enum logic [1:0] {
		CH_RED   = 2'd0,
		CH_GREEN = 2'd1,
		CH_BLUE  = 2'd2,
		CH_ALPHA = 2'd3
	} chan_idx_t;

	// one pixel pair as held in the input stage
	typedef struct packed {
		src_chan_t [NUM_CHAN-1:0] src;
		pix_chan_t [NUM_CHAN-1:0] dst;
		mode_t                    mode;
		logic                     last;
	} in_word_t;

	// one blended pixel as held in the result stage
	typedef struct packed {
		pix_chan_t [NUM_CHAN-1:0] pix;
		logic                     last;
	} out_word_t;

endpackage

// ----- rtl/core/pbm_channel_mix.sv -----
module pbm_channel_mix (
	input  pbm_pkg::mode_t     mode,
	input  pbm_pkg::src_chan_t src,
	input  pbm_pkg::src_chan_t src_a,
	input  pbm_pkg::pix_chan_t dst,
	output pbm_pkg::pix_chan_t mix
);

	logic [7:0]  src_hi;
	logic [16:0] inv_a;
	logic [24:0] prod;
	logic [17:0] over_sum;
	logic [9:0]  over_val;
	logic [8:0]  add_sum;
	logic [7:0]  over_sat;
	logic [7:0]  add_sat;
	logic [7:0]  sub_clamp;

	assign src_hi = src[15:8];

	// over: (s + (((65536 - sa) * d) >> 8)) >> 8, saturate at 255
	assign inv_a    = 17'h10000 - {1'b0, src_a};
	assign prod     = {8'd0, inv_a} * {17'd0, dst};
	assign over_sum = {2'b00, src} + {1'b0, prod[24:8]};
	assign over_val = over_sum[17:8];
	assign over_sat = (over_val[9:8] != 2'b00) ? 8'hff : over_val[7:0];

	// saturating add
	assign add_sum = {1'b0, dst} + {1'b0, src_hi};
	assign add_sat = add_sum[8] ? 8'hff : add_sum[7:0];

	// clamped subtract
	assign sub_clamp = (dst >= src_hi) ? (dst - src_hi) : 8'd0;

	always_comb begin
		case (mode)
			pbm_pkg::MODE_COPY: mix = src_hi;
			pbm_pkg::MODE_OVER: mix = over_sat;
			pbm_pkg::MODE_ADD:  mix = add_sat;
			pbm_pkg::MODE_SUB:  mix = sub_clamp;
			default:            mix = src_hi;
		endcase
	end

endmodule

// ----- rtl/core/pixel_blend_mode_unit.sv -----
// Premultiplied RGBA pixel blender.
// Input: pulse start with a source pixel (16-bit channels) and a destination
// pixel (8-bit channels) plus the span-end mark; the word is taken at a
// rising edge with start high and busy low. busy never rises, so a new
// pixel may be issued every cycle.
// Output: done is high for exactly one cycle with the blended pixel and
// span_end on the result ports; the receiver must take it in that cycle.
// The accepted word passes the input register, then the result register, before
// it appears on the result ports; throughput is one pixel per clock.
// Config: cfg_data selects copy, over, add or subtract; cfg_ready is always
// high and the write lands at an edge with cfg_valid high. Each pixel
// carries the mode in force when it was accepted. Change it while idle.
// Reset: arst_n clears the pipeline valids and sets the mode to over;
// pixels in flight are dropped and nothing is emitted during reset.
module pixel_blend_mode_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [15:0]         src_red,
	input  logic [15:0]         src_green,
	input  logic [15:0]         src_blue,
	input  logic [15:0]         src_alpha,
	input  logic [7:0]          dst_red,
	input  logic [7:0]          dst_green,
	input  logic [7:0]          dst_blue,
	input  logic [7:0]          dst_alpha,
	input  logic                last_in_span,
	output logic                done,
	output logic [7:0]          out_red,
	output logic [7:0]          out_green,
	output logic [7:0]          out_blue,
	output logic [7:0]          out_alpha,
	output logic                span_end,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_data
);

	pbm_pkg::mode_t     mode_q;
	pbm_pkg::in_word_t  word_s1;
	pbm_pkg::out_word_t word_s2;
	pbm_pkg::pix_chan_t [pbm_pkg::NUM_CHAN-1:0] mix;
	logic               valid_s1;
	logic               valid_s2;
	logic               accept;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pbm_pkg::MODE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	// input stage
	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1.src[pbm_pkg::CH_RED]   <= src_red;
			word_s1.src[pbm_pkg::CH_GREEN] <= src_green;
			word_s1.src[pbm_pkg::CH_BLUE]  <= src_blue;
			word_s1.src[pbm_pkg::CH_ALPHA] <= src_alpha;
			word_s1.dst[pbm_pkg::CH_RED]   <= dst_red;
			word_s1.dst[pbm_pkg::CH_GREEN] <= dst_green;
			word_s1.dst[pbm_pkg::CH_BLUE]  <= dst_blue;
			word_s1.dst[pbm_pkg::CH_ALPHA] <= dst_alpha;
			word_s1.mode                   <= mode_q;
			word_s1.last                   <= last_in_span;
		end
	end

	// one mixing lane per channel, all sharing source alpha
	for (genvar c = 0; c < pbm_pkg::NUM_CHAN; c++) begin : g_lane
		pbm_channel_mix u_mix (
			.mode  (word_s1.mode),
			.src   (word_s1.src[c]),
			.src_a (word_s1.src[pbm_pkg::CH_ALPHA]),
			.dst   (word_s1.dst[c]),
			.mix   (mix[c])
		);
	end

	// result stage
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			word_s2.pix  <= mix;
			word_s2.last <= word_s1.last;
		end
	end

	assign done      = valid_s2;
	assign out_red   = word_s2.pix[pbm_pkg::CH_RED];
	assign out_green = word_s2.pix[pbm_pkg::CH_GREEN];
	assign out_blue  = word_s2.pix[pbm_pkg::CH_BLUE];
	assign out_alpha = word_s2.pix[pbm_pkg::CH_ALPHA];
	assign span_end  = word_s2.last;

	// every accepted word comes out through the input and result registers
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("accepted word did not produce a result");

	// span mark follows its pixel
	a_span_mark: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> span_end == $past(last_in_span, 2))
		else $error("span_end does not match its pixel");

	// subtract never raises the red channel above the destination
	a_sub_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(word_s1.mode) == pbm_pkg::MODE_SUB) |->
			out_red <= $past(word_s1.dst[pbm_pkg::CH_RED]))
		else $error("subtract result above destination");

	// add never drops the green channel below the destination
	a_add_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(word_s1.mode) == pbm_pkg::MODE_ADD) |->
			out_green >= $past(word_s1.dst[pbm_pkg::CH_GREEN]))
		else $error("add result below destination");

endmodule
